>>> src/aoc_pkg.sv
package aoc_pkg;

  localparam int unsigned COEF_W  = 16;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned POSE_W  = 3;
  localparam int unsigned ACC_W   = 33;
  localparam int unsigned MULB_W  = 17;
  localparam int unsigned PROD_W  = ACC_W + MULB_W;
  localparam int unsigned Q_SHIFT = 14;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam logic [1:0] REG_COS   = 2'd0;
  localparam logic [1:0] REG_SIN   = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  localparam logic signed [COEF_W-1:0] COS_RESET   = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RESET   = 16'sd0;
  localparam logic        [COEF_W-1:0] SCALE_RESET = 16'd4089;

  localparam longint G_ONE  = 1048576;
  localparam longint G_TOL1 = 209715;
  localparam longint G_TOL0 = 419430;
  localparam longint Q_MUL  = longint'(1) << Q_SHIFT;

  localparam logic signed [PROD_W-1:0] POS_LO  = PROD_W'((G_ONE - G_TOL1) * Q_MUL);
  localparam logic signed [PROD_W-1:0] POS_HI  = PROD_W'((G_ONE + G_TOL1) * Q_MUL);
  localparam logic signed [PROD_W-1:0] NEG_LO  = PROD_W'((-G_ONE - G_TOL1) * Q_MUL);
  localparam logic signed [PROD_W-1:0] NEG_HI  = PROD_W'((-G_ONE + G_TOL1) * Q_MUL);
  localparam logic signed [PROD_W-1:0] ZERO_LO = PROD_W'((-G_TOL0) * Q_MUL);
  localparam logic signed [PROD_W-1:0] ZERO_HI = PROD_W'(G_TOL0 * Q_MUL);

  typedef enum logic [POSE_W-1:0] {
    POSE_UNKNOWN = 3'd0,
    POSE_UP      = 3'd1,
    POSE_DOWN    = 3'd2,
    POSE_LEFT    = 3'd3,
    POSE_RIGHT   = 3'd4,
    POSE_FRONT   = 3'd5,
    POSE_BACK    = 3'd6
  } pose_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
    logic        [COEF_W-1:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    logic pos;
    logic neg;
    logic zero;
  } axis_flags_t;

  typedef struct packed {
    logic  push;
    pose_t pose;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    pose_t pose;
  } q_rd_t;

  function automatic axis_flags_t near_flags(input logic signed [PROD_W-1:0] v);
    axis_flags_t f;
    f.pos  = (v > POS_LO)  && (v < POS_HI);
    f.neg  = (v > NEG_LO)  && (v < NEG_HI);
    f.zero = (v > ZERO_LO) && (v < ZERO_HI);
    return f;
  endfunction

  function automatic axis_flags_t flip_flags(input axis_flags_t f);
    axis_flags_t r;
    r.pos  = f.neg;
    r.neg  = f.pos;
    r.zero = f.zero;
    return r;
  endfunction

endpackage

>>> src/aoc_in_if.sv
interface aoc_in_if;
  import aoc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] x_raw;
  logic signed [SAMP_W-1:0] y_raw;
  logic signed [SAMP_W-1:0] z_raw;

  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

>>> src/aoc_out_if.sv
interface aoc_out_if;
  import aoc_pkg::*;

  logic              valid;
  logic              ready;
  logic [POSE_W-1:0] pose_code;
  logic              pose_changed;

  modport source (output valid, pose_code, pose_changed, input ready);
  modport sink   (input valid, pose_code, pose_changed, output ready);
endinterface

>>> src/aoc_cfg.sv
module aoc_cfg
  import aoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_coef     <= COS_RESET;
      cfg_r.sin_coef     <= SIN_RESET;
      cfg_r.scale_factor <= SCALE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_COS:   cfg_r.cos_coef     <= pwdata[COEF_W-1:0];
        REG_SIN:   cfg_r.sin_coef     <= pwdata[COEF_W-1:0];
        REG_SCALE: cfg_r.scale_factor <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COS:   prdata = APB_DW'(cfg_r.cos_coef);
      REG_SIN:   prdata = APB_DW'(cfg_r.sin_coef);
      REG_SCALE: prdata = {{(APB_DW-COEF_W){1'b0}}, cfg_r.scale_factor};
      default:   prdata = '0;
    endcase
  end

endmodule

>>> src/aoc_front.sv
module aoc_front
  import aoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  aoc_in_if.sink      in_if,
  input  logic        q_full,
  output q_wr_t       q_wr
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SY   = 8'b0000_0010,
    ST_KX   = 8'b0000_0100,
    ST_SX   = 8'b0000_1000,
    ST_CY   = 8'b0001_0000,
    ST_KY   = 8'b0010_0000,
    ST_KZ   = 8'b0100_0000,
    ST_CLS  = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [SAMP_W-1:0]  x_r, y_r, z_r;
  axis_flags_t               xf_r, xf_nxt, yf_r, yf_nxt, zf_r, zf_nxt;
  logic signed [ACC_W-1:0]   mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_q34;
  logic                      accept;
  pose_t                     found;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        mul_a = ACC_W'(cfg.cos_coef);
        mul_b = MULB_W'(in_if.x_raw);
      end
      ST_SY: begin
        mul_a = ACC_W'(cfg.sin_coef);
        mul_b = MULB_W'(y_r);
      end
      ST_SX: begin
        mul_a = ACC_W'(cfg.sin_coef);
        mul_b = MULB_W'(x_r);
      end
      ST_CY: begin
        mul_a = ACC_W'(cfg.cos_coef);
        mul_b = MULB_W'(y_r);
      end
      ST_KX, ST_KY: begin
        mul_a = acc_r;
        mul_b = {1'b0, cfg.scale_factor};
      end
      ST_KZ: begin
        mul_a = ACC_W'(z_r);
        mul_b = {1'b0, cfg.scale_factor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_q34 = {prod[PROD_W-1-Q_SHIFT:0], {Q_SHIFT{1'b0}}};

  // Y and Z are the negated products, so their +1/-1 windows swap.
  always_comb begin
    found = POSE_UNKNOWN;
    if (xf_r.pos  && yf_r.zero && zf_r.zero) found = POSE_RIGHT;
    if (xf_r.neg  && yf_r.zero && zf_r.zero) found = POSE_LEFT;
    if (xf_r.zero && yf_r.pos  && zf_r.zero) found = POSE_UP;
    if (xf_r.zero && yf_r.neg  && zf_r.zero) found = POSE_DOWN;
    if (xf_r.zero && yf_r.zero && zf_r.pos)  found = POSE_BACK;
    if (xf_r.zero && yf_r.zero && zf_r.neg)  found = POSE_FRONT;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    xf_nxt    = xf_r;
    yf_nxt    = yf_r;
    zf_nxt    = zf_r;
    q_wr.push = 1'b0;
    q_wr.pose = found;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = prod[ACC_W-1:0];
          state_nxt = ST_SY;
        end
      end
      ST_SY: begin
        acc_nxt   = acc_r - prod[ACC_W-1:0];
        state_nxt = ST_KX;
      end
      ST_KX: begin
        xf_nxt    = near_flags(prod);
        state_nxt = ST_SX;
      end
      ST_SX: begin
        acc_nxt   = prod[ACC_W-1:0];
        state_nxt = ST_CY;
      end
      ST_CY: begin
        acc_nxt   = acc_r + prod[ACC_W-1:0];
        state_nxt = ST_KY;
      end
      ST_KY: begin
        yf_nxt    = flip_flags(near_flags(prod));
        state_nxt = ST_KZ;
      end
      ST_KZ: begin
        zf_nxt    = flip_flags(near_flags(prod_q34));
        state_nxt = ST_CLS;
      end
      ST_CLS: begin
        if (!q_full) begin
          q_wr.push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    xf_r  <= xf_nxt;
    yf_r  <= yf_nxt;
    zf_r  <= zf_nxt;
    if (accept) begin
      x_r <= in_if.x_raw;
      y_r <= in_if.y_raw;
      z_r <= in_if.z_raw;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SY)
    else $error("front did not start multiply sequence after transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("front pushed into a full queue");

endmodule

>>> src/aoc_queue.sv
module aoc_queue
  import aoc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  pop,
  output q_rd_t q_rd
);

  pose_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_full     = (cnt_r == QCNT_W'(QDEPTH));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.pose  = mem[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && !q_rd.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= q_wr.pose;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_rd.empty))
    else $error("pop from empty queue");

endmodule

>>> src/aoc_back.sv
module aoc_back
  import aoc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_rd_t   q_rd,
  output logic    pop,
  aoc_out_if.source out_if
);

  pose_t held_r, held_nxt;
  logic  valid_r;
  logic  chg_r, chg_nxt;
  logic  take;

  assign pop = !q_rd.empty && (!valid_r || out_if.ready);

  assign out_if.valid        = valid_r;
  assign out_if.pose_code    = held_r;
  assign out_if.pose_changed = chg_r;

  assign take = (q_rd.pose != POSE_UNKNOWN) && (q_rd.pose != held_r);

  always_comb begin
    held_nxt = held_r;
    chg_nxt  = chg_r;
    if (pop) begin
      chg_nxt = take;
      if (take) held_nxt = q_rd.pose;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= POSE_UNKNOWN;
      valid_r <= 1'b0;
      chg_r   <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      chg_r   <= chg_nxt;
      if (pop) begin
        valid_r <= 1'b1;
      end else if (out_if.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && chg_r |-> held_r != POSE_UNKNOWN)
    else $error("pose change reported to unknown");

  assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(held_r))
    else $error("held pose moved without a queue pop");

endmodule

>>> src/accel_orientation_classifier.sv
// An input transaction passes through the front sequencer, then the queue, into
// the output register. The front takes no new transaction until the last one
// is pushed to the queue (a full queue stalls it), as the single shared
// multiplier forms the seven rotation and scale products in turn.
// Reset (rst_n low, synchronous): held pose unknown, queue empty, output
// invalid, registers back to cos 1.0, sin 0, scale 4089.
module accel_orientation_classifier
  import aoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  aoc_in_if.sink            in_if,
  aoc_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  aoc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  aoc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  aoc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  aoc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

>>> dv/aoc_checker.sv
module aoc_checker
  import aoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  aoc_in_if                 in_mon,
  aoc_out_if                out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  input  logic [APB_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                n_errors,
  output int                n_pending,
  output int                n_results,
  output int                n_changes
);

  // Window bounds in Q.34 g
  localparam longint Q34_SCALE = 64'sd16384;
  localparam longint ONE_Q34   = 64'sd1048576 * Q34_SCALE;
  localparam longint TOL1_Q34  = 64'sd209715 * Q34_SCALE;
  localparam longint TOL0_Q34  = 64'sd419430 * Q34_SCALE;

  typedef struct packed {
    pose_t pose;
    logic  changed;
  } pose_report_t;

  cfg_t         regs;
  pose_t        held;
  pose_report_t report_q[$];
  int           n_accepted;

  assign n_pending = n_accepted - n_results;

  function automatic bit in_band(longint v, longint mid, longint tol);
    return (v > mid - tol) && (v < mid + tol);
  endfunction

  function automatic pose_t classify(cfg_t r, logic signed [SAMP_W-1:0] x,
                                     logic signed [SAMP_W-1:0] y,
                                     logic signed [SAMP_W-1:0] z);
    longint c, s, k, gx, gy, gz;
    bit px, nx, zx, py, ny, zy, pz, nz, zz;
    pose_t found;
    c  = longint'($signed(r.cos_coef));
    s  = longint'($signed(r.sin_coef));
    k  = longint'($unsigned(r.scale_factor));
    gx = k * (c * longint'(x) - s * longint'(y));
    gy = -(k * (s * longint'(x) + c * longint'(y)));
    gz = -(k * longint'(z)) * Q34_SCALE;
    px = in_band(gx, ONE_Q34, TOL1_Q34);
    nx = in_band(gx, -ONE_Q34, TOL1_Q34);
    zx = in_band(gx, 0, TOL0_Q34);
    py = in_band(gy, ONE_Q34, TOL1_Q34);
    ny = in_band(gy, -ONE_Q34, TOL1_Q34);
    zy = in_band(gy, 0, TOL0_Q34);
    pz = in_band(gz, ONE_Q34, TOL1_Q34);
    nz = in_band(gz, -ONE_Q34, TOL1_Q34);
    zz = in_band(gz, 0, TOL0_Q34);
    found = POSE_UNKNOWN;
    if (px && zy && zz) found = POSE_RIGHT;
    if (nx && zy && zz) found = POSE_LEFT;
    if (zx && py && zz) found = POSE_UP;
    if (zx && ny && zz) found = POSE_DOWN;
    if (zx && zy && pz) found = POSE_BACK;
    if (zx && zy && nz) found = POSE_FRONT;
    return found;
  endfunction

  always @(posedge clk) begin : mon
    pose_report_t want;
    pose_t        found;
    int           errs;
    logic [COEF_W-1:0] reg_val;
    errs = 0;
    if (!rst_n) begin
      regs <= '{cos_coef: COS_RESET, sin_coef: SIN_RESET, scale_factor: SCALE_RESET};
      held <= POSE_UNKNOWN;
      report_q.delete();
      n_accepted <= 0;
      n_results  <= 0;
      n_changes  <= 0;
      n_errors   <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[APB_AW-1:2])
            REG_COS:   regs.cos_coef     <= cfg_pwdata[COEF_W-1:0];
            REG_SIN:   regs.sin_coef     <= cfg_pwdata[COEF_W-1:0];
            REG_SCALE: regs.scale_factor <= cfg_pwdata[COEF_W-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[APB_AW-1:2])
            REG_COS:   reg_val = regs.cos_coef;
            REG_SIN:   reg_val = regs.sin_coef;
            REG_SCALE: reg_val = regs.scale_factor;
            default:   reg_val = '0;
          endcase
          if (cfg_prdata[COEF_W-1:0] !== reg_val) begin
            errs++;
            if (n_errors < 40)
              $display("%0t: readback addr %0d expected %h got %h", $time, cfg_paddr,
                       reg_val, cfg_prdata[COEF_W-1:0]);
          end
        end
      end

      // results first: an input seen on this edge cannot have its result yet
      if (out_mon.valid && out_mon.ready) begin
        n_results <= n_results + 1;
        if (report_q.size() == 0) begin
          errs++;
          if (n_errors < 40)
            $display("%0t: unexpected transaction, expected none got pose %0d changed %0d",
                     $time, out_mon.pose_code, out_mon.pose_changed);
        end else begin
          want = report_q.pop_front();
          if (out_mon.pose_code !== want.pose) begin
            errs++;
            if (n_errors < 40)
              $display("%0t: pose_code expected %0d got %0d", $time, want.pose,
                       out_mon.pose_code);
          end
          if (out_mon.pose_changed !== want.changed) begin
            errs++;
            if (n_errors < 40)
              $display("%0t: pose_changed expected %0d got %0d", $time, want.changed,
                       out_mon.pose_changed);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        found = classify(regs, in_mon.x_raw, in_mon.y_raw, in_mon.z_raw);
        want.changed = (found != POSE_UNKNOWN) && (found != held);
        want.pose    = want.changed ? found : held;
        held <= want.pose;
        report_q.push_back(want);
        n_accepted <= n_accepted + 1;
        if (want.changed) n_changes <= n_changes + 1;
      end
      n_errors <= n_errors + errs;
    end
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  import aoc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0]  REG_NONE    = 2'd3;
  localparam int          N_PHASES    = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int          n_errors;
  int          n_pending;
  int          n_results;
  int          n_changes;
  int          n_sent;
  int unsigned cycle_count = 0;
  bit          steady;

  aoc_in_if  in_ch();
  aoc_out_if out_ch();

  accel_orientation_classifier DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  aoc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_results   (n_results),
    .n_changes   (n_changes)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d transactions outstanding", cycle_count,
               n_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_sample(input logic signed [SAMP_W-1:0] x,
                             input logic signed [SAMP_W-1:0] y,
                             input logic signed [SAMP_W-1:0] z);
    while (!steady && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_raw <= x;
    in_ch.y_raw <= y;
    in_ch.z_raw <= z;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic reg_read(input logic [1:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input int c, input int s, input int k);
    reg_write(REG_COS, c);
    reg_write(REG_SIN, s);
    reg_write(REG_SCALE, k);
    reg_read(REG_COS);
    reg_read(REG_SIN);
    reg_read(REG_SCALE);
    cfg_release();
  endtask

  // block holds no hidden work once every result is out; short settle anyway
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic real jitter(real span);
    return span * ($itor($urandom_range(2000)) - 1000.0) / 1000.0;
  endfunction

  function automatic logic signed [SAMP_W-1:0] to_raw(real v);
    if (v > 32767.0) v = 32767.0;
    if (v < -32768.0) v = -32768.0;
    return SAMP_W'($rtoi(v < 0.0 ? v - 0.5 : v + 0.5));
  endfunction

  // Pick a pose target in g with jitter around the window edges, then undo
  // the rotation and scaling to get raw counts.
  task automatic aim_at_pose(input int c, input int s, input int k,
                             output logic signed [SAMP_W-1:0] x,
                             output logic signed [SAMP_W-1:0] y,
                             output logic signed [SAMP_W-1:0] z);
    real tgt[3];
    real cr, sr, kg, det, u, v, sgn;
    int  axis;
    cr   = $itor(c) / 16384.0;
    sr   = $itor(s) / 16384.0;
    kg   = $itor(k) / 1048576.0;
    det  = cr * cr + sr * sr;
    axis = $urandom_range(2);
    sgn  = $urandom_range(1) ? 1.0 : -1.0;
    for (int i = 0; i < 3; i++)
      tgt[i] = (i == axis) ? sgn * (1.0 + jitter(0.25)) : jitter(0.45);
    if (k == 0 || det < 1.0e-6) begin
      x = SAMP_W'($urandom);
      y = SAMP_W'($urandom);
      z = SAMP_W'($urandom);
    end else begin
      u = tgt[0] / kg;
      v = -tgt[1] / kg;
      x = to_raw((cr * u + sr * v) / det);
      y = to_raw((cr * v - sr * u) / det);
      z = to_raw(-tgt[2] / kg);
    end
  endtask

  task automatic phase_setting(input int ph, output int c, output int s, output int k,
                               output int n);
    n = 210;
    case (ph)
      0: begin c = 0;      s = 16384;  k = 4089;  end
      1: begin c = 11585;  s = 11585;  k = 4089;  end
      2: begin c = -16384; s = 0;      k = 65535; end
      3: begin c = 16384;  s = -16384; k = 0;     n = 60; end
      4: begin c = 32767;  s = -32768; k = 2048;  end
      5: begin c = -11585; s = -11585; k = 8192;  end
      6: begin
        c = $urandom_range(65535) - 32768;
        s = $urandom_range(65535) - 32768;
        k = $urandom_range(65535, 1);
      end
      default: begin c = -32768; s = 32767; k = 65535; end
    endcase
  endtask

  initial begin
    int c, s, k, n, sel;
    logic signed [SAMP_W-1:0] x, y, z;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.x_raw <= '0;
    in_ch.y_raw <= '0;
    in_ch.z_raw <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    n_sent = 0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_read(REG_COS);
    reg_read(REG_SIN);
    reg_read(REG_SCALE);
    cfg_release();

    // reset setting: about 256 counts per g
    send_sample(0, 0, 0);
    send_sample(256, 0, 0);
    send_sample(256, 0, 0);
    send_sample(-256, 0, 0);
    send_sample(0, -256, 0);
    send_sample(0, 256, 0);
    send_sample(0, 0, -256);
    send_sample(0, 0, 256);
    send_sample(206, 102, -102);
    send_sample(205, 0, 0);
    send_sample(308, 0, 0);
    send_sample(307, -102, 102);
    send_sample(256, 103, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 0);
    send_sample(-32768, 0, 32767);
    send_sample(0, 0, 0);

    // scale where 33 counts land exactly on the near-zero limit
    drain();
    program_regs(16384, 0, 12710);
    send_sample(0, 0, -82);
    send_sample(33, 0, -82);
    send_sample(32, 0, -82);
    send_sample(0, -33, 82);
    send_sample(0, -32, 82);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      phase_setting(ph, c, s, k, n);
      if (ph == 3) reg_write(REG_NONE, $urandom);
      program_regs(c, s, k);
      steady = (ph == 2);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          aim_at_pose(c, s, k, x, y, z);
        end else if (sel < 85) begin
          x = SAMP_W'($urandom);
          y = SAMP_W'($urandom);
          z = SAMP_W'($urandom);
        end else begin
          x = SAMP_W'($urandom_range(1200) - 600);
          y = SAMP_W'($urandom_range(1200) - 600);
          z = SAMP_W'($urandom_range(1200) - 600);
        end
        send_sample(x, y, z);
      end
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (20) @(posedge clk);
    $display("%0d samples over %0d register settings, incl. out-of-range coefficients",
             n_sent, N_PHASES + 2);
    $display("%0d results compared, %0d pose changes, %0d errors", n_results, n_changes,
             n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
